FILE: rtl/fadc_window_charge_extractor_defines.svh
// ----------------------------------------------------------------------------
// FADC window charge extractor - assertion macros
// Shared concurrent assertion forms for the extractor's RTL modules.
// ----------------------------------------------------------------------------
`ifndef FADC_WINDOW_CHARGE_EXTRACTOR_DEFINES_SVH
`define FADC_WINDOW_CHARGE_EXTRACTOR_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define FWCE_ASSERT_NOW(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FWCE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/fwce_pkg.sv
// ----------------------------------------------------------------------------
// FADC window charge extractor - package
// Types, register codes, limits and helpers shared by the extractor modules.
// ----------------------------------------------------------------------------
package fwce_pkg;

  // Slices beyond this never fall inside a window
  localparam int unsigned MAX_SLICES = 64;

  localparam logic [13:0] SUM_MAX   = 14'h3FFF;
  localparam logic [6:0]  CNT_MAX   = 7'h7F;
  localparam logic [18:0] NOISE_MAX = 19'h7FFFF;
  localparam logic signed [25:0] SIG_MAX = 26'sh07FFFFF;
  localparam logic signed [25:0] SIG_MIN = -26'sh0800000;

  typedef enum logic [2:0] {
    REG_HI_FIRST  = 3'd0,
    REG_HI_COUNT  = 3'd1,
    REG_LO_FIRST  = 3'd2,
    REG_LO_COUNT  = 3'd3,
    REG_SAT_LIMIT = 3'd4,
    REG_SQRT_HI   = 3'd5,
    REG_SQRT_LO   = 3'd6
  } fwce_reg_t;

  typedef struct packed {
    logic [5:0]  hi_first;
    logic [6:0]  hi_count;
    logic [5:0]  lo_first;
    logic [6:0]  lo_count;
    logic [7:0]  saturation_limit;
    logic [11:0] sqrt_hi_scale;
    logic [11:0] sqrt_lo_scale;
  } fwce_cfg_t;

  // One finished pixel, handed from the accumulator to the arithmetic
  typedef struct packed {
    logic [9:0]         pixel_id;
    logic [13:0]        sum_high;
    logic [13:0]        sum_low;
    logic [6:0]         sat_high;
    logic [6:0]         sat_low;
    logic               ab_flag;
    logic [15:0]        pedestal;
    logic [15:0]        pedestal_rms;
    logic signed [15:0] ab_offset;
  } fwce_entry_t;

  typedef struct packed {
    logic [9:0]         pixel_out;
    logic signed [23:0] signal_high;
    logic [18:0]        noise_high;
    logic signed [23:0] signal_low;
    logic [18:0]        noise_low;
    logic [6:0]         saturated_high;
    logic [6:0]         saturated_low;
  } fwce_result_t;

  function automatic logic in_window(logic [5:0] slice, logic [5:0] first,
                                     logic [6:0] count);
    logic [5:0] diff;
    diff = slice - first;
    return (9'(slice) < 9'(MAX_SLICES)) && (slice >= first) && ({1'b0, diff} < count);
  endfunction

  function automatic logic [13:0] sat_add(logic [13:0] sum, logic [7:0] s);
    logic [14:0] t;
    t = {1'b0, sum} + 15'(s);
    return (t > {1'b0, SUM_MAX}) ? SUM_MAX : t[13:0];
  endfunction

endpackage

FILE: rtl/fwce_front.sv
// ----------------------------------------------------------------------------
// FADC window charge extractor - front accumulator
// Classifies each sample by gain and window, sums it and counts saturation;
// pushes the pixel's totals to the queue on its last sample.
// ----------------------------------------------------------------------------
`include "fadc_window_charge_extractor_defines.svh"

module fwce_front (
  input  logic                 clk,
  input  logic                 rst,
  input  fwce_pkg::fwce_cfg_t  cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           sample,
  input  logic                 low_gain,
  input  logic [5:0]           slice_index,
  input  logic [9:0]           pixel_id,
  input  logic                 ab_flag,
  input  logic [15:0]          pedestal,
  input  logic [15:0]          pedestal_rms,
  input  logic signed [15:0]   ab_offset,
  input  logic                 last_sample,
  input  logic                 queue_full,
  output logic                 push,
  output fwce_pkg::fwce_entry_t push_entry
);

  logic [13:0] sum_high, sum_low, sum_high_next, sum_low_next;
  logic [6:0]  sat_high, sat_low, sat_high_next, sat_low_next;
  logic        hit_high, hit_low, is_sat, take;

  assign in_ready = !queue_full;
  assign take     = in_valid && in_ready;
  assign push     = take && last_sample;

  always_comb begin
    hit_high = !low_gain && fwce_pkg::in_window(slice_index, cfg.hi_first, cfg.hi_count);
    hit_low  = low_gain && fwce_pkg::in_window(slice_index, cfg.lo_first, cfg.lo_count);
    is_sat   = sample >= cfg.saturation_limit;

    sum_high_next = hit_high ? fwce_pkg::sat_add(sum_high, sample) : sum_high;
    sum_low_next  = hit_low ? fwce_pkg::sat_add(sum_low, sample) : sum_low;
    sat_high_next = (hit_high && is_sat && sat_high != fwce_pkg::CNT_MAX)
                    ? sat_high + 7'd1 : sat_high;
    sat_low_next  = (hit_low && is_sat && sat_low != fwce_pkg::CNT_MAX)
                    ? sat_low + 7'd1 : sat_low;

    push_entry.pixel_id     = pixel_id;
    push_entry.sum_high     = sum_high_next;
    push_entry.sum_low      = sum_low_next;
    push_entry.sat_high     = sat_high_next;
    push_entry.sat_low      = sat_low_next;
    push_entry.ab_flag      = ab_flag;
    push_entry.pedestal     = pedestal;
    push_entry.pedestal_rms = pedestal_rms;
    push_entry.ab_offset    = ab_offset;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_high <= '0;
      sum_low  <= '0;
      sat_high <= '0;
      sat_low  <= '0;
    end else if (take) begin
      if (last_sample) begin
        sum_high <= '0;
        sum_low  <= '0;
        sat_high <= '0;
        sat_low  <= '0;
      end else begin
        sum_high <= sum_high_next;
        sum_low  <= sum_low_next;
        sat_high <= sat_high_next;
        sat_low  <= sat_low_next;
      end
    end
  end

  `FWCE_ASSERT_NEXT(a_clear_after_last, clk, rst, push,
    (sum_high == '0 && sum_low == '0 && sat_high == '0 && sat_low == '0),
    "accumulators not cleared after last sample")

endmodule

FILE: rtl/fwce_queue.sv
// ----------------------------------------------------------------------------
// FADC window charge extractor - pixel queue
// Short first-in first-out buffer of finished pixels between front and back.
// ----------------------------------------------------------------------------
`include "fadc_window_charge_extractor_defines.svh"

module fwce_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  fwce_pkg::fwce_entry_t push_entry,
  input  logic                  pop,
  output fwce_pkg::fwce_entry_t head,
  output logic                  full,
  output logic                  empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  fwce_pkg::fwce_entry_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = count == CNT_W'(DEPTH);
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `FWCE_ASSERT_NOW(a_count_bound, clk, rst, (count <= CNT_W'(DEPTH)),
    "queue count beyond depth")
  `FWCE_ASSERT_NEXT(a_count_grows, clk, rst, (push && !pop),
    (count == $past(count) + CNT_W'(1)), "queue count did not advance on push")

endmodule

FILE: rtl/fwce_back.sv
// ----------------------------------------------------------------------------
// FADC window charge extractor - back arithmetic
// Two-stage pipeline: products and A/B correction, then signal and noise
// saturation into the output register.
// ----------------------------------------------------------------------------
`include "fadc_window_charge_extractor_defines.svh"

module fwce_back (
  input  logic                   clk,
  input  logic                   rst,
  input  fwce_pkg::fwce_cfg_t    cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  fwce_pkg::fwce_entry_t  in_entry,
  output logic                   out_valid,
  input  logic                   out_ready,
  output fwce_pkg::fwce_result_t out_result
);

  // Stage 1 registers
  logic               s1_valid;
  logic [9:0]         s1_pixel;
  logic [13:0]        s1_sum_high, s1_sum_low;
  logic [6:0]         s1_sat_high, s1_sat_low;
  logic [22:0]        s1_ped_high, s1_ped_low;
  logic [27:0]        s1_rms_high, s1_rms_low;
  logic signed [16:0] s1_adj_high, s1_adj_low;

  logic               out_free, s1_ready;
  logic signed [16:0] off_ext, adj_high, adj_low;
  logic signed [25:0] sig_high_raw, sig_low_raw;
  logic [28:0]        nz_high_rnd, nz_low_rnd;
  logic signed [23:0] sig_high, sig_low;
  logic [18:0]        nz_high, nz_low;

  assign out_free = !out_valid || out_ready;
  assign s1_ready = !s1_valid || out_free;
  assign in_ready = s1_ready;

  // A/B correction, odd counts: subtract offset when first plus phase is even
  always_comb begin
    off_ext  = {in_entry.ab_offset[15], in_entry.ab_offset};
    adj_high = '0;
    adj_low  = '0;
    if (cfg.hi_count[0]) begin
      adj_high = (cfg.hi_first[0] ^ in_entry.ab_flag) ? off_ext : -off_ext;
    end
    if (cfg.lo_count[0]) begin
      adj_low = (cfg.lo_first[0] ^ in_entry.ab_flag) ? off_ext : -off_ext;
    end
  end

  always_comb begin
    sig_high_raw = $signed({4'b0, s1_sum_high, 8'b0}) - $signed({3'b0, s1_ped_high})
                   + 26'(s1_adj_high);
    sig_low_raw  = $signed({4'b0, s1_sum_low, 8'b0}) - $signed({3'b0, s1_ped_low})
                   + 26'(s1_adj_low);
    if (sig_high_raw > fwce_pkg::SIG_MAX) begin
      sig_high = fwce_pkg::SIG_MAX[23:0];
    end else if (sig_high_raw < fwce_pkg::SIG_MIN) begin
      sig_high = fwce_pkg::SIG_MIN[23:0];
    end else begin
      sig_high = sig_high_raw[23:0];
    end
    if (sig_low_raw > fwce_pkg::SIG_MAX) begin
      sig_low = fwce_pkg::SIG_MAX[23:0];
    end else if (sig_low_raw < fwce_pkg::SIG_MIN) begin
      sig_low = fwce_pkg::SIG_MIN[23:0];
    end else begin
      sig_low = sig_low_raw[23:0];
    end

    // Round half up to Q11.8, then clamp
    nz_high_rnd = {1'b0, s1_rms_high} + 29'd128;
    nz_low_rnd  = {1'b0, s1_rms_low} + 29'd128;
    nz_high = (nz_high_rnd[28:27] != 2'b00) ? fwce_pkg::NOISE_MAX : nz_high_rnd[26:8];
    nz_low  = (nz_low_rnd[28:27] != 2'b00) ? fwce_pkg::NOISE_MAX : nz_low_rnd[26:8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_pixel    <= in_entry.pixel_id;
      s1_sum_high <= in_entry.sum_high;
      s1_sum_low  <= in_entry.sum_low;
      s1_sat_high <= in_entry.sat_high;
      s1_sat_low  <= in_entry.sat_low;
      s1_ped_high <= 23'(in_entry.pedestal) * 23'(cfg.hi_count);
      s1_ped_low  <= 23'(in_entry.pedestal) * 23'(cfg.lo_count);
      s1_rms_high <= 28'(in_entry.pedestal_rms) * 28'(cfg.sqrt_hi_scale);
      s1_rms_low  <= 28'(in_entry.pedestal_rms) * 28'(cfg.sqrt_lo_scale);
      s1_adj_high <= adj_high;
      s1_adj_low  <= adj_low;
    end
    if (out_free && s1_valid) begin
      out_result.pixel_out      <= s1_pixel;
      out_result.signal_high    <= sig_high;
      out_result.noise_high     <= nz_high;
      out_result.signal_low     <= sig_low;
      out_result.noise_low      <= nz_low;
      out_result.saturated_high <= s1_sat_high;
      out_result.saturated_low  <= s1_sat_low;
    end
  end

  `FWCE_ASSERT_NEXT(a_stage1_holds, clk, rst, (s1_valid && !s1_ready),
    (s1_valid && $stable(s1_pixel) && $stable(s1_sum_high)),
    "stage one lost its pixel under stall")

endmodule

FILE: rtl/fadc_window_charge_extractor.sv
// ----------------------------------------------------------------------------
// FADC window charge extractor - top level
// Fixed-window charge integration with pedestal subtraction, A/B clock
// correction, noise scaling and saturation counting per pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Samples of one pixel enter on the s_ stream, one word each, high- and
//   low-gain interleaved in any order; s_tuser marks a low-gain sample and
//   s_tlast the pixel's final sample. Each pixel gives one result word on the
//   m_ stream, in arrival order.
//   Throughput: one sample word per cycle while s_tready is high, including
//   last samples. A result passes the queue slot, product stage and output
//   register before it shows on m_tvalid. The user writes the window
//   registers through the APB port only while idle; the block does not
//   enforce it. Reset clears the sums, the saturation counts, the queue and
//   the pipeline, and loads the register defaults; no clearing pass follows.
//   When the receiver stalls, the output word holds, the product stage and
//   then the queue of QUEUE_DEPTH finished pixels fill; s_tready drops only
//   once that queue is full, so non-final samples are never held up earlier.
//   The accumulator sets the rate: one sample per cycle while s_tready is high.
// ----------------------------------------------------------------------------
`include "fadc_window_charge_extractor_defines.svh"

module fadc_window_charge_extractor #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  // Sample stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // [7:0] sample, [13:8] slice_index, [23:14] pixel_id, [24] ab_flag,
  // [40:25] pedestal, [56:41] pedestal_rms, [72:57] ab_offset, rest zero
  input  logic [79:0]  s_tdata,
  input  logic         s_tuser,    // [0] low_gain
  input  logic         s_tlast,    // last_sample
  // Result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // [9:0] pixel_out, [33:10] signal_high, [52:34] noise_high,
  // [76:53] signal_low, [95:77] noise_low, [102:96] saturated_high,
  // [109:103] saturated_low, rest zero
  output logic [111:0] m_tdata,
  // Register port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  fwce_pkg::fwce_cfg_t    cfg;
  fwce_pkg::fwce_reg_t    reg_sel;
  fwce_pkg::fwce_entry_t  push_entry, head;
  fwce_pkg::fwce_result_t result;
  logic                   push, pop, queue_full, queue_empty, back_ready;
  logic                   cfg_write;

  // Register port: always ready, write on the access cycle
  assign pready    = 1'b1;
  assign reg_sel   = fwce_pkg::fwce_reg_t'(paddr[4:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hi_first         <= 6'd3;
      cfg.hi_count         <= 7'd12;
      cfg.lo_first         <= 6'd3;
      cfg.lo_count         <= 7'd12;
      cfg.saturation_limit <= 8'd254;
      cfg.sqrt_hi_scale    <= 12'd887;
      cfg.sqrt_lo_scale    <= 12'd887;
    end else if (cfg_write) begin
      unique case (reg_sel)
        fwce_pkg::REG_HI_FIRST:  cfg.hi_first         <= pwdata[5:0];
        fwce_pkg::REG_HI_COUNT:  cfg.hi_count         <= pwdata[6:0];
        fwce_pkg::REG_LO_FIRST:  cfg.lo_first         <= pwdata[5:0];
        fwce_pkg::REG_LO_COUNT:  cfg.lo_count         <= pwdata[6:0];
        fwce_pkg::REG_SAT_LIMIT: cfg.saturation_limit <= pwdata[7:0];
        fwce_pkg::REG_SQRT_HI:   cfg.sqrt_hi_scale    <= pwdata[11:0];
        fwce_pkg::REG_SQRT_LO:   cfg.sqrt_lo_scale    <= pwdata[11:0];
        default: begin
          // drop writes to the unused slot
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      fwce_pkg::REG_HI_FIRST:  prdata = 32'(cfg.hi_first);
      fwce_pkg::REG_HI_COUNT:  prdata = 32'(cfg.hi_count);
      fwce_pkg::REG_LO_FIRST:  prdata = 32'(cfg.lo_first);
      fwce_pkg::REG_LO_COUNT:  prdata = 32'(cfg.lo_count);
      fwce_pkg::REG_SAT_LIMIT: prdata = 32'(cfg.saturation_limit);
      fwce_pkg::REG_SQRT_HI:   prdata = 32'(cfg.sqrt_hi_scale);
      fwce_pkg::REG_SQRT_LO:   prdata = 32'(cfg.sqrt_lo_scale);
      default:                 prdata = '0;
    endcase
  end

  // Front: classify and accumulate, hand over finished pixels
  fwce_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .sample       (s_tdata[7:0]),
    .low_gain     (s_tuser),
    .slice_index  (s_tdata[13:8]),
    .pixel_id     (s_tdata[23:14]),
    .ab_flag      (s_tdata[24]),
    .pedestal     (s_tdata[40:25]),
    .pedestal_rms (s_tdata[56:41]),
    .ab_offset    ($signed(s_tdata[72:57])),
    .last_sample  (s_tlast),
    .queue_full   (queue_full),
    .push         (push),
    .push_entry   (push_entry)
  );

  // Queue: decouple the accumulator from a stalled receiver
  fwce_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (queue_full),
    .empty      (queue_empty)
  );

  assign pop = !queue_empty && back_ready;

  // Back: products, correction, saturation, output register
  fwce_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (!queue_empty),
    .in_ready   (back_ready),
    .in_entry   (head),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (result)
  );

  // Pack the result word, first field lowest
  assign m_tdata = {2'b00, result.saturated_low, result.saturated_high,
                    result.noise_low, result.signal_low, result.noise_high,
                    result.signal_high, result.pixel_out};

endmodule
